### hdl/bdp_pkg.sv
// Shared types and constants for the branch direction predictor.
// No dependencies; imported by every module of the block but bdp_ram.
package bdp_pkg;

    // Field widths fixed by the item format.
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;

    // Low address bits dropped before indexing (word-aligned instructions).
    localparam int IDX_SHIFT = 2;

    // The shifted address is folded in chunks of this many bits.
    localparam int CHUNK_W    = 5;
    localparam int NUM_CHUNKS = (ADDR_W - IDX_SHIFT) / CHUNK_W;

    // Operation codes.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Saturation value for the counters.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Control part of an item as it moves down the pipeline.
    typedef struct packed {
        logic op;
        logic taken;
    } t_item;

    // One table entry: direction and hysteresis.
    typedef struct packed {
        logic dir;
        logic hyst;
    } t_entry;

endpackage

### hdl/bdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; returns old data on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bdp_index.sv
// Two-stage index unit: reduces (address >> 2) modulo the table size.
// Depends on bdp_pkg.
module bdp_index #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  bdp_pkg::t_item                   i_item,
    input  logic [bdp_pkg::ADDR_W-1:0]       i_address,
    output logic                             o_valid,
    output bdp_pkg::t_item                   o_item,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_index
);

    import bdp_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int KEY_W     = ADDR_W - IDX_SHIFT;
    localparam int CHUNK_N   = 1 << CHUNK_W;
    localparam int SUM_W     = $clog2(NUM_CHUNKS * TABLE_ENTRIES);
    localparam int RED_STEPS = $clog2(NUM_CHUNKS);

    // Modular add of two residues, both below the table size.
    function automatic int add_mod(int a, int b);
        int s;
        s = a + b;
        if (s >= TABLE_ENTRIES) begin
            s = s - TABLE_ENTRIES;
        end
        return s;
    endfunction

    // Residue of 2**e modulo the table size, by repeated doubling.
    function automatic int pow2_mod(int e);
        int r;
        r = 1;
        for (int j = 0; j < e; j++) begin
            r = add_mod(r, r);
        end
        return r;
    endfunction

    // Residue of chunk value v placed at chunk position k.
    function automatic int chunk_res(int k, int v);
        int base;
        int res;
        base = pow2_mod(CHUNK_W * k);
        res  = 0;
        for (int b = 0; b < CHUNK_W; b++) begin
            if (((v >> b) & 1) != 0) begin
                res = add_mod(res, base);
            end
            base = add_mod(base, base);
        end
        return res;
    endfunction

    logic [KEY_W-1:0] w_key;
    logic [IDX_W-1:0] w_tbl [NUM_CHUNKS][CHUNK_N];
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_red;

    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [SUM_W-1:0] r_s1_sum;
    logic             r_s2_valid;
    t_item            r_s2_item;
    logic [IDX_W-1:0] r_s2_index;

    assign w_key = i_address[ADDR_W-1:IDX_SHIFT];

    // Constant residue tables, one per address chunk.
    for (genvar k = 0; k < NUM_CHUNKS; k++) begin : g_chunk
        for (genvar v = 0; v < CHUNK_N; v++) begin : g_val
            assign w_tbl[k][v] = IDX_W'(chunk_res(k, v));
        end
    end

    // Sum of the chunk residues; stays below NUM_CHUNKS times the table size.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_CHUNKS; k++) begin
            w_sum = w_sum + SUM_W'(w_tbl[k][w_key[k*CHUNK_W +: CHUNK_W]]);
        end
    end

    // Final reduction by conditional subtraction of shifted table sizes.
    always_comb begin
        w_red = r_s1_sum;
        for (int j = RED_STEPS - 1; j >= 0; j--) begin
            if (w_red >= SUM_W'(TABLE_ENTRIES << j)) begin
                w_red = w_red - SUM_W'(TABLE_ENTRIES << j);
            end
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item  <= i_item;
            r_s1_sum   <= w_sum;
            r_s2_item  <= r_s1_item;
            r_s2_index <= w_red[IDX_W-1:0];
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;
    assign o_index = r_s2_index;

endmodule

### hdl/bdp_entry_update.sv
// Next-state logic of one predictor entry with hysteresis.
// Depends on bdp_pkg.
module bdp_entry_update (
    input  bdp_pkg::t_entry i_entry,
    input  logic            i_taken,
    output bdp_pkg::t_entry o_entry,
    output logic            o_hit
);

    import bdp_pkg::*;

    // A hit clears hysteresis, a first miss sets it, a second miss flips direction.
    always_comb begin
        o_hit = (i_entry.dir == i_taken);
        if (o_hit) begin
            o_entry.dir  = i_entry.dir;
            o_entry.hyst = 1'b0;
        end else if (i_entry.hyst) begin
            o_entry.dir  = i_taken;
            o_entry.hyst = 1'b0;
        end else begin
            o_entry.dir  = i_entry.dir;
            o_entry.hyst = 1'b1;
        end
    end

endmodule

### hdl/branch_direction_predictor_core.sv
// Top level of the two-bit branch direction predictor with hysteresis.
// Depends on bdp_pkg, bdp_ram, bdp_index and bdp_entry_update.
//
// Usage:
// - Input channel (i_valid / o_ready) carries i_op, i_address and i_taken.
//   i_op selects a predict lookup or an update with the resolved outcome.
// - Output channel (o_valid / i_ready) returns one result beat per input
//   beat, in order: the entry's direction before any update and the
//   saturating update and correct-prediction counts after the item.
// - Items pass two index stages, stage 3 and the output register. One item
//   per cycle unless the receiver stalls; the table read-modify-write is one
//   RAM read port and one write port with a bypass of the last written entry.
// - After reset the table is cleared one entry per cycle, with o_ready low;
//   the counters reset to zero at once.
// - When the receiver stalls, the whole pipeline holds and o_ready drops
//   while a result is waiting to be taken.
module branch_direction_predictor_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [bdp_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_taken,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_prediction,
    output logic [bdp_pkg::CNT_W-1:0]  o_total_count,
    output logic [bdp_pkg::CNT_W-1:0]  o_correct_count
);

    import bdp_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = $bits(t_entry);

    logic             w_en;
    t_item            w_in_item;
    logic             w_s2_valid;
    t_item            w_s2_item;
    logic [IDX_W-1:0] w_s2_index;
    t_entry           w_rdata;
    t_entry           w_entry;
    t_entry           w_next_entry;
    logic             w_hit;
    logic             w_upd;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_s3_valid;
    t_item            r_s3_item;
    logic [IDX_W-1:0] r_s3_index;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_index;
    t_entry           r_fwd_entry;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_correct;
    logic [CNT_W-1:0] n_total;
    logic [CNT_W-1:0] n_correct;
    logic             r_o_valid;
    logic             r_o_prediction;
    logic [CNT_W-1:0] r_o_total;
    logic [CNT_W-1:0] r_o_correct;

    // The pipeline advances whenever the output register is free or drains.
    assign w_en      = !r_o_valid || i_ready;
    assign o_ready   = w_en && !r_clr_busy;
    assign w_in_item = '{op: i_op, taken: i_taken};

    bdp_index #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid && o_ready),
        .i_item   (w_in_item),
        .i_address(i_address),
        .o_valid  (w_s2_valid),
        .o_item   (w_s2_item),
        .o_index  (w_s2_index)
    );

    // Clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Table write: the sweep has priority, otherwise the update in stage 3.
    assign w_upd   = r_s3_valid && (r_s3_item.op == OP_UPDATE);
    assign w_we    = r_clr_busy || (w_en && w_upd);
    assign w_waddr = r_clr_busy ? r_clr_addr : r_s3_index;
    assign w_wdata = r_clr_busy ? t_entry'('0) : w_next_entry;

    bdp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_en),
        .i_raddr(w_s2_index),
        .o_rdata(w_rdata)
    );

    // Stage 3 registers, aligned with the RAM read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= w_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_item  <= w_s2_item;
            r_s3_index <= w_s2_index;
        end
    end

    // Bypass of the most recent table update, which the read may have missed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_en && w_upd && !r_clr_busy) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_upd && !r_clr_busy) begin
            r_fwd_index <= r_s3_index;
            r_fwd_entry <= w_next_entry;
        end
    end

    assign w_entry = (r_fwd_valid && (r_fwd_index == r_s3_index)) ? r_fwd_entry : w_rdata;

    bdp_entry_update u_update (
        .i_entry(w_entry),
        .i_taken(r_s3_item.taken),
        .o_entry(w_next_entry),
        .o_hit  (w_hit)
    );

    // Saturating counters.
    always_comb begin
        n_total   = r_total;
        n_correct = r_correct;
        if (w_upd) begin
            if (r_total != CNT_MAX) begin
                n_total = r_total + 1'b1;
            end
            if (w_hit && (r_correct != CNT_MAX)) begin
                n_correct = r_correct + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_correct <= '0;
        end else if (w_en) begin
            r_total   <= n_total;
            r_correct <= n_correct;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s3_valid) begin
            r_o_prediction <= w_entry.dir;
            r_o_total      <= n_total;
            r_o_correct    <= n_correct;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_prediction    = r_o_prediction;
    assign o_total_count   = r_o_total;
    assign o_correct_count = r_o_correct;

endmodule

### test/branch_direction_predictor_core_tb.sv
// Testbench for branch_direction_predictor_core: directed table plus random beats,
// every result checked against its typed row or a behavioral direction-table copy.
// Depends on bdp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module branch_direction_predictor_core_tb;
    import bdp_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int HALF_PERIOD   = 6;
    localparam int RAND_PER_PHASE = 360;
    localparam int NUM_PHASES    = 4;
    localparam int DIRECTED_ROWS = 21;

    // One directed row: the beat to send and, where marked, the result typed in.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic              taken;
        logic              typed;
        logic              pred;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  correct;
    } t_stim_row;

    typedef struct packed {
        logic             pred;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] correct;
    } t_bdp_result;

    // Index 0 is trained and flipped both ways, index 31 reached by the top addresses.
    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
        '{OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd1, 32'd1},
        '{OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'd3, 32'd1},
        '{OP_UPDATE,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'd7, 32'd2},
        '{OP_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'hFFFF_FFFC, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_PREDICT, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'd9, 32'd2},
        '{OP_PREDICT, 32'h0000_007C, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0080, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0003, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_PREDICT, 32'h0000_0004, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{OP_UPDATE,  32'h5555_5555, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}
    };

    // Idle percentages per phase: none, sender, receiver, both.
    localparam int SEND_IDLE [0:NUM_PHASES-1] = '{0, 85, 0, 36};
    localparam int RECV_IDLE [0:NUM_PHASES-1] = '{0, 0, 85, 36};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_op = OP_PREDICT;
    logic [ADDR_W-1:0] i_address = '0;
    logic              i_taken = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_prediction;
    logic [CNT_W-1:0]  o_total_count;
    logic [CNT_W-1:0]  o_correct_count;

    // Behavioral copy of the table and counters.
    logic              dir_bits  [TABLE_ENTRIES];
    logic              hyst_bits [TABLE_ENTRIES];
    logic [CNT_W-1:0]  updates_seen = '0;
    logic [CNT_W-1:0]  hits_seen = '0;

    t_bdp_result pending_results [$];
    int          err_count = 0;
    int          results_checked = 0;
    int          predicts_sent = 0;
    int          updates_sent = 0;
    int          direction_flips = 0;
    int          beats_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          taken_bias = 50;

    branch_direction_predictor_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_taken        (i_taken),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_prediction   (o_prediction),
        .o_total_count  (o_total_count),
        .o_correct_count(o_correct_count)
    );

    // Clock generation.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Reads the entry, then trains it the way the block should on an update.
    function automatic t_bdp_result lookup_and_train(input logic op,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic taken);
        logic [IDX_W-1:0] idx;
        t_bdp_result      res;
        idx = IDX_W'((addr >> IDX_SHIFT) % TABLE_ENTRIES);
        res.pred = dir_bits[idx];
        if (op == OP_UPDATE) begin
            if (updates_seen != CNT_MAX) updates_seen = updates_seen + 1'b1;
            if (dir_bits[idx] == taken) begin
                if (hits_seen != CNT_MAX) hits_seen = hits_seen + 1'b1;
                hyst_bits[idx] = 1'b0;
            end else if (hyst_bits[idx]) begin
                // Second miss in a row turns the entry around.
                dir_bits[idx]  = taken;
                hyst_bits[idx] = 1'b0;
                direction_flips++;
            end else begin
                hyst_bits[idx] = 1'b1;
            end
        end
        res.total   = updates_seen;
        res.correct = hits_seen;
        return res;
    endfunction

    // Drives one beat with optional idle cycles first; stores its expected result.
    task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic taken, input logic typed,
                             input t_bdp_result typed_res);
        t_bdp_result res;
        int          idle_pct;
        // Every 80 beats a run of 16 goes out back to back.
        idle_pct = ((beats_sent % 80) < 16) ? 0 : send_idle_pct;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_address <= addr;
        i_taken   <= taken;
        do @(posedge i_clk); while (!o_ready);
        res = lookup_and_train(op, addr, taken);
        pending_results.push_back(typed ? typed_res : res);
        beats_sent++;
        if (op == OP_UPDATE) updates_sent++;
        else predicts_sent++;
    endtask

    // Waits at the edge until every expected result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Address mix: mostly a few busy entries with random upper and lower bits.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] addr;
        logic [4:0]        idx;
        addr = $urandom();
        if ($urandom_range(99) < 65) begin
            case ($urandom_range(3))
                0: idx = 5'd0;
                1: idx = 5'd9;
                2: idx = 5'd22;
                default: idx = 5'd31;
            endcase
            addr[6:2] = idx;
        end
        return addr;
    endfunction

    // Receiver: random stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: each beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_bdp_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_prediction !== want.pred) begin
                    $error("prediction mismatch: expected %0d, got %0d",
                           want.pred, o_prediction);
                    err_count++;
                end
                if (o_total_count !== want.total) begin
                    $error("total_count mismatch: expected %0d, got %0d",
                           want.total, o_total_count);
                    err_count++;
                end
                if (o_correct_count !== want.correct) begin
                    $error("correct_count mismatch: expected %0d, got %0d",
                           want.correct, o_correct_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("FAIL branch_direction_predictor_core");
        $finish;
    end

    // Main sequence.
    initial begin
        t_bdp_result typed_res;
        t_stim_row   row;
        logic        op;
        int          wait_cycles;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            dir_bits[k]  = 1'b0;
            hyst_bits[k] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            typed_res.pred    = row.pred;
            typed_res.total   = row.total;
            typed_res.correct = row.correct;
            send_beat(row.op, row.addr, row.taken, row.typed, typed_res);
        end
        drain_results();

        // Random phases; the sender waits for all results between phases.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            recv_idle_pct = RECV_IDLE[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 100 == 0) begin
                    case ($urandom_range(2))
                        0: taken_bias = 10;
                        1: taken_bias = 50;
                        default: taken_bias = 90;
                    endcase
                end
                op = ($urandom_range(99) < 55) ? OP_UPDATE : OP_PREDICT;
                send_beat(op, pick_address(), ($urandom_range(99) < taken_bias),
                          1'b0, typed_res);
            end
            drain_results();
        end

        // Let the pipeline settle, then look for anything left over.
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end
        repeat (8) @(posedge i_clk);

        $display("Covered %0d beats (%0d predicts, %0d updates), %0d results checked.",
                 beats_sent, predicts_sent, updates_sent, results_checked);
        $display("Table entries turned around %0d times under four idle patterns.",
                 direction_flips);
        if (err_count == 0) begin
            $display("PASS branch_direction_predictor_core");
        end else begin
            $display("FAIL branch_direction_predictor_core");
        end
        $finish;
    end

endmodule

### files.f
hdl/bdp_pkg.sv
hdl/bdp_ram.sv
hdl/bdp_index.sv
hdl/bdp_entry_update.sv
hdl/branch_direction_predictor_core.sv
test/branch_direction_predictor_core_tb.sv
